### hw/rtl/match_timer_interrupt_controller_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the match timer interrupt controller
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MATCH_TIMER_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH
`define MATCH_TIMER_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define MTIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MTIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mtic_pkg.sv
// ----------------------------------------------------------------------------
// mtic_pkg
// Types, request codes and default parameters of the match timer interrupt
// controller.
// ----------------------------------------------------------------------------
package mtic_pkg;

  localparam int DEFAULT_TIMER0_BIT = 2;
  localparam int DEFAULT_GPIO_BIT   = 10;
  localparam int DEFAULT_NUM_MATCH  = 4;

  typedef enum logic [3:0] {
    REQ_TICK        = 4'd0,
    REQ_RAISE       = 4'd1,
    REQ_CLEAR       = 4'd2,
    REQ_GPIO_RAISE  = 4'd3,
    REQ_GPIO_CLEAR  = 4'd4,
    REQ_MATCH_WRITE = 4'd5,
    REQ_INT_ENABLE  = 4'd6,
    REQ_GPIO_ENABLE = 4'd7,
    REQ_WAIT        = 4'd8
  } req_code_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] data_value;
    logic [1:0]  match_index;
    logic        wait_ignore_irq;
    logic        wait_ignore_fiq;
  } in_item_t;

  typedef struct packed {
    logic        irq_line;
    logic        fiq_line;
    logic [31:0] pending_bits;
    logic        next_valid;
    logic [31:0] next_match;
    logic        wake;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } next_t;

endpackage

### hw/rtl/mtic_fire.sv
// ----------------------------------------------------------------------------
// mtic_fire
// Window compare of every match register against the tick interval
// (old, now], with wraparound. Returns the timer interrupt bits to raise.
// ----------------------------------------------------------------------------
module mtic_fire #(
  parameter int TIMER0_BIT = mtic_pkg::DEFAULT_TIMER0_BIT,
  parameter int NUM_MATCH  = mtic_pkg::DEFAULT_NUM_MATCH
) (
  input  logic [31:0] timer_old,
  input  logic [31:0] timer_now,
  input  logic [31:0] match_values [NUM_MATCH],
  output logic [31:0] fire_bits
);

  logic [NUM_MATCH-1:0] hit;

  always_comb begin
    for (int i = 0; i < NUM_MATCH; i++) begin
      if (timer_old < timer_now) begin
        hit[i] = (timer_old < match_values[i]) && (match_values[i] <= timer_now);
      end else if (timer_old > timer_now) begin
        // interval wraps past zero
        hit[i] = (timer_old < match_values[i]) || (match_values[i] <= timer_now);
      end else begin
        hit[i] = (match_values[i] == timer_now);
      end
    end
  end

  always_comb begin
    fire_bits = '0;
    for (int i = 0; i < NUM_MATCH; i++) begin
      fire_bits[TIMER0_BIT + i] = hit[i];
    end
  end

endmodule

### hw/rtl/mtic_next.sv
// ----------------------------------------------------------------------------
// mtic_next
// Nearest upcoming match: among matches whose interrupt bit is clear, pick
// the smallest circular distance from the timer; the lowest index wins ties.
// ----------------------------------------------------------------------------
module mtic_next #(
  parameter int TIMER0_BIT = mtic_pkg::DEFAULT_TIMER0_BIT,
  parameter int NUM_MATCH  = mtic_pkg::DEFAULT_NUM_MATCH
) (
  input  logic [31:0]   timer,
  input  logic [31:0]   vector,
  input  logic [31:0]   match_values [NUM_MATCH],
  output mtic_pkg::next_t next
);

  logic [31:0] span [NUM_MATCH];

  for (genvar i = 0; i < NUM_MATCH; i++) begin : g_span
    assign span[i] = match_values[i] - timer;
  end

  always_comb begin
    logic [31:0] best_span;
    best_span  = '0;
    next.valid = 1'b0;
    next.value = '0;
    for (int i = 0; i < NUM_MATCH; i++) begin
      if (!vector[TIMER0_BIT + i]) begin
        if (!next.valid || (span[i] < best_span)) begin
          best_span  = span[i];
          next.value = match_values[i];
          next.valid = 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/mtic_state.sv
// ----------------------------------------------------------------------------
// mtic_state
// Controller state and request decode. On each step one request updates the
// state and the result for it is formed from the updated state.
// ----------------------------------------------------------------------------
module mtic_state #(
  parameter int TIMER0_BIT = mtic_pkg::DEFAULT_TIMER0_BIT,
  parameter int GPIO_BIT   = mtic_pkg::DEFAULT_GPIO_BIT,
  parameter int NUM_MATCH  = mtic_pkg::DEFAULT_NUM_MATCH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  mtic_pkg::in_item_t  item,
  input  logic [31:0]         fast_mask,
  output mtic_pkg::out_item_t result
);

  localparam logic [31:0] GpioMask = 32'd1 << GPIO_BIT;

  logic [31:0] last_timer;
  logic [31:0] match_store [NUM_MATCH];
  logic [31:0] raised_vector;
  logic [31:0] int_enable;
  logic [31:0] gpio_pending;
  logic [31:0] gpio_enable;
  logic        waiting_flag;
  logic [1:0]  wait_masks;

  logic [31:0] last_timer_next;
  logic [31:0] match_store_next [NUM_MATCH];
  logic [31:0] raised_vector_next;
  logic [31:0] int_enable_next;
  logic [31:0] gpio_pending_next;
  logic [31:0] gpio_enable_next;
  logic        waiting_flag_next;
  logic [1:0]  wait_masks_next;

  logic [31:0]     fire_bits;
  logic            set_wait;
  logic            wake_gpio;
  logic            wake;
  logic [31:0]     active;
  logic            fiq;
  logic            irq;
  mtic_pkg::next_t next;

  mtic_fire #(
    .TIMER0_BIT(TIMER0_BIT),
    .NUM_MATCH (NUM_MATCH)
  ) u_fire (
    .timer_old   (last_timer),
    .timer_now   (item.data_value),
    .match_values(match_store),
    .fire_bits   (fire_bits)
  );

  always_comb begin
    for (int i = 0; i < NUM_MATCH; i++) begin
      match_store_next[i] = match_store[i];
      if ((item.req_type == mtic_pkg::REQ_MATCH_WRITE) && (item.match_index == 2'(i))) begin
        match_store_next[i] = item.data_value;
      end
    end
  end

  always_comb begin
    last_timer_next    = last_timer;
    raised_vector_next = raised_vector;
    int_enable_next    = int_enable;
    gpio_pending_next  = gpio_pending;
    gpio_enable_next   = gpio_enable;
    set_wait           = 1'b0;
    wait_masks_next    = wait_masks;
    wake_gpio          = 1'b0;
    case (item.req_type)
      mtic_pkg::REQ_TICK: begin
        raised_vector_next = raised_vector | fire_bits;
        last_timer_next    = item.data_value;
      end
      mtic_pkg::REQ_RAISE: begin
        raised_vector_next = raised_vector | item.data_value;
      end
      mtic_pkg::REQ_CLEAR: begin
        raised_vector_next = raised_vector & ~item.data_value;
      end
      mtic_pkg::REQ_GPIO_RAISE: begin
        gpio_pending_next = gpio_pending | item.data_value;
        if ((gpio_enable & gpio_pending_next) != '0) begin
          raised_vector_next = raised_vector | GpioMask;
          // a GPIO event releases the waiter whatever its masks
          wake_gpio          = waiting_flag;
        end
      end
      mtic_pkg::REQ_GPIO_CLEAR: begin
        gpio_pending_next = gpio_pending & ~item.data_value;
      end
      mtic_pkg::REQ_INT_ENABLE: begin
        int_enable_next = item.data_value;
      end
      mtic_pkg::REQ_GPIO_ENABLE: begin
        if (item.data_value != gpio_enable) begin
          gpio_enable_next = item.data_value;
          if ((item.data_value & gpio_pending) != '0) begin
            raised_vector_next = raised_vector | GpioMask;
          end
        end
      end
      mtic_pkg::REQ_WAIT: begin
        set_wait        = 1'b1;
        wait_masks_next = {item.wait_ignore_fiq, item.wait_ignore_irq};
      end
      default: begin
      end
    endcase

    active = raised_vector_next & int_enable_next;
    fiq    = (active & fast_mask) != '0;
    irq    = (active & ~fast_mask) != '0;
    wake   = wake_gpio || ((waiting_flag || set_wait) &&
             ((fiq && !wait_masks_next[1]) || (irq && !wait_masks_next[0])));
    waiting_flag_next = (waiting_flag || set_wait) && !wake;
  end

  mtic_next #(
    .TIMER0_BIT(TIMER0_BIT),
    .NUM_MATCH (NUM_MATCH)
  ) u_next (
    .timer       (last_timer_next),
    .vector      (raised_vector_next),
    .match_values(match_store_next),
    .next        (next)
  );

  always_comb begin
    result.irq_line     = irq;
    result.fiq_line     = fiq;
    result.pending_bits = raised_vector_next;
    result.next_valid   = next.valid;
    result.next_match   = next.value;
    result.wake         = wake;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_timer    <= '0;
      raised_vector <= '0;
      int_enable    <= '0;
      gpio_pending  <= '0;
      gpio_enable   <= '0;
      waiting_flag  <= 1'b0;
      wait_masks    <= '0;
      for (int i = 0; i < NUM_MATCH; i++) begin
        match_store[i] <= '0;
      end
    end else if (step) begin
      last_timer    <= last_timer_next;
      raised_vector <= raised_vector_next;
      int_enable    <= int_enable_next;
      gpio_pending  <= gpio_pending_next;
      gpio_enable   <= gpio_enable_next;
      waiting_flag  <= waiting_flag_next;
      wait_masks    <= wait_masks_next;
      for (int i = 0; i < NUM_MATCH; i++) begin
        match_store[i] <= match_store_next[i];
      end
    end
  end

endmodule

### hw/rtl/match_timer_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// match_timer_interrupt_controller_top
// Interrupt controller with match timers: request register, state update and
// result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item  (mtic_pkg::in_item_t)
//   out      output     out_valid/ out_stall out_item (mtic_pkg::out_item_t)
//   cfg      input      cfg_write            cfg_data (fast route mask)
//
// Requests pass the request register, then the result register; one request
// per cycle is sustained while the output is not stalled.
// Reset is synchronous and clears all state; no clearing pass is needed.
// A stalled output holds its result; the request register then holds and
// in_stall rises only once that register is full.
// ----------------------------------------------------------------------------
module match_timer_interrupt_controller_top #(
  parameter int TIMER0_BIT = mtic_pkg::DEFAULT_TIMER0_BIT,
  parameter int GPIO_BIT   = mtic_pkg::DEFAULT_GPIO_BIT,
  parameter int NUM_MATCH  = mtic_pkg::DEFAULT_NUM_MATCH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mtic_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mtic_pkg::out_item_t out_item,
  input  logic                cfg_write,
  input  logic [31:0]         cfg_data
);

  `include "match_timer_interrupt_controller_top_assert.svh"

  logic                req_valid;
  mtic_pkg::in_item_t  req_item;
  logic [31:0]         fast_route_mask;
  logic                advance;
  logic                in_transfer;
  mtic_pkg::out_item_t result;

  assign advance     = req_valid && (!out_valid || !out_stall);
  assign in_stall    = req_valid && !advance;
  assign in_transfer = in_valid && !in_stall;

  mtic_state #(
    .TIMER0_BIT(TIMER0_BIT),
    .GPIO_BIT  (GPIO_BIT),
    .NUM_MATCH (NUM_MATCH)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (req_item),
    .fast_mask(fast_route_mask),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid       <= 1'b0;
      out_valid       <= 1'b0;
      fast_route_mask <= '0;
    end else begin
      req_valid <= in_transfer || (req_valid && !advance);
      out_valid <= advance || (out_valid && out_stall);
      if (cfg_write) begin
        fast_route_mask <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer) begin
      req_item <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  `MTIC_ASSERT_NOW(a_no_stall_when_out_free, !out_stall, !in_stall, "input stalled with output free")
  `MTIC_ASSERT_NEXT(a_advance_loads_out, advance, out_valid, "result lost after advance")
  `MTIC_ASSERT_NOW(a_lines_need_pending, out_valid && (out_item.irq_line || out_item.fiq_line), out_item.pending_bits != '0, "line active with nothing pending")
  `MTIC_ASSERT_NOW(a_next_zero_when_none, out_valid && !out_item.next_valid, out_item.next_match == '0, "next match nonzero without a candidate")

endmodule
